### hdl/assert_macros.svh
// Assertion helpers used by the checker file spi_check.sv.
// Each macro samples on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SPI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SPI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SPI_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Widths, register codes and types for the segment/plane intersection block.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int CRD_W      = 32;              // Q16.16 coordinate
  localparam int DIF_W      = CRD_W + 1;       // end - start
  localparam int NRM_W      = 18;              // Q2.16 normal component
  localparam int OFF_W      = 40;              // Q24.16 offset
  localparam int TOL_W      = 16;              // Q0.16 tolerance
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = NRM_W + CRD_W;   // normal * coordinate, Q.32
  localparam int DIST_W     = 58;              // signed distance, Q.32
  localparam int SMAG_W     = 56;              // |s0|
  localparam int DEN_W      = SMAG_W + 1;      // |s0| + |s1|
  localparam int SPLIT_W    = SMAG_W / 2;
  localparam int PP_W       = CRD_W + SPLIT_W; // partial product
  localparam int DVD_W      = PP_W + SPLIT_W;  // full dividend
  localparam int DIV_STEPS  = CRD_W;           // quotient bits
  localparam int Q_W        = DIV_STEPS + 1;   // rounded quotient
  localparam int SUM_W      = CRD_W + 2;       // start +/- step
  localparam int NUM_STAGES = DIV_STEPS + 6;   // pipeline depth
  localparam int AXES       = 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = OFF_W;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

  localparam logic [NRM_W-1:0] NORMAL_X_RST  = 18'sd0;
  localparam logic [NRM_W-1:0] NORMAL_Y_RST  = 18'sd65536;
  localparam logic [NRM_W-1:0] NORMAL_Z_RST  = 18'sd0;
  localparam logic [OFF_W-1:0] OFFSET_RST    = 40'sd0;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 16'd655;

  // Side data that rides along with the divider lanes.
  typedef struct packed {
    logic                       hit;
    logic                       sop;
    logic [AXES-1:0]            neg;
    logic [AXES-1:0][CRD_W-1:0] org;
  } side_t;

endpackage

### hdl/spi_if.sv
// ----------------------------------------------------------------------------
// spi_in_if / spi_out_if
// Valid/ready channels for segment beats and intersection result beats.
// ----------------------------------------------------------------------------
interface spi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;

  modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 input ready);
  modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
               output ready);
endinterface

interface spi_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;
  logic signed [31:0] cross_z;
  logic               start_on_plane;

  modport source(output valid, hit, cross_x, cross_y, cross_z, start_on_plane,
                 input ready);
  modport sink(input valid, hit, cross_x, cross_y, cross_z, start_on_plane,
               output ready);
endinterface

### hdl/spi_dist.sv
// ----------------------------------------------------------------------------
// spi_dist
// Two-stage signed distance of both endpoints: products, then sums.
// ----------------------------------------------------------------------------
module spi_dist import spi_pkg::*; (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic [AXES-1:0][CRD_W-1:0]        p0,
  input  logic [AXES-1:0][CRD_W-1:0]        p1,
  input  logic [AXES-1:0][NRM_W-1:0]        nrm,
  input  logic [OFF_W-1:0]                  offset,
  output logic signed [DIST_W-1:0]          s0_r,
  output logic signed [DIST_W-1:0]          s1_r
);

  logic signed [PROD_W-1:0] pr0_r [AXES];
  logic signed [PROD_W-1:0] pr1_r [AXES];
  logic signed [DIST_W-1:0] off_ext;
  logic signed [DIST_W-1:0] s0_nxt;
  logic signed [DIST_W-1:0] s1_nxt;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < AXES; i++) begin
        pr0_r[i] <= $signed(nrm[i]) * $signed(p0[i]);
        pr1_r[i] <= $signed(nrm[i]) * $signed(p1[i]);
      end
    end
  end

  assign off_ext = $signed({{(DIST_W-OFF_W-FRAC_W){offset[OFF_W-1]}}, offset,
                            {FRAC_W{1'b0}}});
  assign s0_nxt  = pr0_r[0] + pr0_r[1] + pr0_r[2] + off_ext;
  assign s1_nxt  = pr1_r[0] + pr1_r[1] + pr1_r[2] + off_ext;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
    end
  end

endmodule

### hdl/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div
// One axis lane: split multiply |d|*|s0|, then a restoring divider by the
// distance span, one quotient bit per stage.
// ----------------------------------------------------------------------------
module spi_div import spi_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_STEPS+1:0] en,
  input  logic [CRD_W-1:0]     dm,
  input  logic [SMAG_W-1:0]    s0m,
  input  logic [DEN_W-1:0]     den,
  output logic [DIV_STEPS-1:0] quo,
  output logic [DEN_W-1:0]     rem,
  output logic [DEN_W-1:0]     den_o
);

  logic [PP_W-1:0]      pl_r;
  logic [PP_W-1:0]      ph_r;
  logic [DEN_W-1:0]     den4_r;
  logic [DEN_W-1:0]     den5_r;
  logic [DVD_W-1:0]     dvd_r;

  logic [DEN_W-1:0]     rem_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_r  [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_r    [DIV_STEPS];
  logic [DEN_W-1:0]     dd_r   [DIV_STEPS];

  logic [DEN_W-1:0]     rem_in [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_in [DIV_STEPS];
  logic [DIV_STEPS-1:0] q_in   [DIV_STEPS];
  logic [DEN_W-1:0]     dd_in  [DIV_STEPS];
  logic [DEN_W:0]       trial  [DIV_STEPS];
  logic                 ge     [DIV_STEPS];
  logic [DEN_W-1:0]     rem_nxt[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_r   <= dm * s0m[SPLIT_W-1:0];
      ph_r   <= dm * s0m[SMAG_W-1:SPLIT_W];
      den4_r <= den;
    end
    if (en[1]) begin
      dvd_r  <= DVD_W'(pl_r) + {ph_r, {SPLIT_W{1'b0}}};
      den5_r <= den4_r;
    end
  end

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (j == 0) begin
        rem_in[j] = DEN_W'(dvd_r[DVD_W-1:DIV_STEPS]);
        low_in[j] = dvd_r[DIV_STEPS-1:0];
        q_in[j]   = '0;
        dd_in[j]  = den5_r;
      end else begin
        rem_in[j] = rem_r[j-1];
        low_in[j] = low_r[j-1];
        q_in[j]   = q_r[j-1];
        dd_in[j]  = dd_r[j-1];
      end
      trial[j]   = {rem_in[j], low_in[j][DIV_STEPS-1]};
      ge[j]      = trial[j] >= {1'b0, dd_in[j]};
      rem_nxt[j] = ge[j] ? DEN_W'(trial[j] - {1'b0, dd_in[j]}) : trial[j][DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (en[j+2]) begin
        rem_r[j] <= rem_nxt[j];
        low_r[j] <= {low_in[j][DIV_STEPS-2:0], 1'b0};
        q_r[j]   <= {q_in[j][DIV_STEPS-2:0], ge[j]};
        dd_r[j]  <= dd_in[j];
      end
    end
  end

  assign quo   = q_r[DIV_STEPS-1];
  assign rem   = rem_r[DIV_STEPS-1];
  assign den_o = dd_r[DIV_STEPS-1];

endmodule

### hdl/segment_plane_intersection.sv
// ----------------------------------------------------------------------------
// segment_plane_intersection
// Streams segments against a configured plane and returns the crossing point.
// ----------------------------------------------------------------------------
// Takes one segment beat per cycle while the output is not stalled, and returns
// one result beat per segment, in order. The depth is set by the
// 32-stage restoring divider (one quotient bit per stage) that forms
// |p1-p0|*|s0|/(|s0|+|s1|) for each axis; around it sit two stages of distance
// math, one stage of sign and magnitude setup, a split multiply over two
// stages, and the rounding/output register. Each stage advances whenever
// the stage after it is empty or moving, so bubbles squeeze out and new beats
// keep entering while a finished result waits at the output. The plane
// (normal, offset, tolerance) is written through the cfg_ port and must only
// change while no segment is in flight.
module segment_plane_intersection import spi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  spi_in_if.sink                in_bus,
  spi_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Plane registers.
  logic [AXES-1:0][NRM_W-1:0] nrm_r;
  logic [OFF_W-1:0]           off_r;
  logic [TOL_W-1:0]           tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= NORMAL_X_RST;
      nrm_r[1] <= NORMAL_Y_RST;
      nrm_r[2] <= NORMAL_Z_RST;
      off_r    <= OFFSET_RST;
      tol_r    <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X:  nrm_r[0] <= cfg_data[NRM_W-1:0];
        REG_NORMAL_Y:  nrm_r[1] <= cfg_data[NRM_W-1:0];
        REG_NORMAL_Z:  nrm_r[2] <= cfg_data[NRM_W-1:0];
        REG_OFFSET:    off_r    <= cfg_data[OFF_W-1:0];
        REG_TOLERANCE: tol_r    <= cfg_data[TOL_W-1:0];
        default: ;     // drop writes to unknown indexes
      endcase
    end
  end

  // Stage valids and advance enables. Stage k loads when it is empty or
  // when stage k+1 loads; the last stage is the output register.
  logic [NUM_STAGES:1] v_r;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !v_r[NUM_STAGES] | out_bus.ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_r[k] | en[k+1];
    end
  end

  assign in_bus.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_bus.valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stages 1-2: distances, with start point and direction carried alongside.
  logic [AXES-1:0][CRD_W-1:0] p0;
  logic [AXES-1:0][CRD_W-1:0] p1;
  logic signed [DIST_W-1:0]   s0;
  logic signed [DIST_W-1:0]   s1;
  logic [CRD_W-1:0]           a1_r [AXES];
  logic signed [DIF_W-1:0]    d1_r [AXES];
  logic [CRD_W-1:0]           a2_r [AXES];
  logic signed [DIF_W-1:0]    d2_r [AXES];

  assign p0[0] = in_bus.start_x;
  assign p0[1] = in_bus.start_y;
  assign p0[2] = in_bus.start_z;
  assign p1[0] = in_bus.end_x;
  assign p1[1] = in_bus.end_y;
  assign p1[2] = in_bus.end_z;

  spi_dist u_dist (
    .clk    (clk),
    .en     (en[2:1]),
    .p0     (p0),
    .p1     (p1),
    .nrm    (nrm_r),
    .offset (off_r),
    .s0_r   (s0),
    .s1_r   (s1)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      if (en[1]) begin
        a1_r[i] <= p0[i];
        d1_r[i] <= $signed({p1[i][CRD_W-1], p1[i]}) - $signed({p0[i][CRD_W-1], p0[i]});
      end
      if (en[2]) begin
        a2_r[i] <= a1_r[i];
        d2_r[i] <= d1_r[i];
      end
    end
  end

  // Stage 3: crossing test, start-on-plane test, magnitudes.
  logic                     hit_nxt;
  logic                     sop_nxt;
  logic signed [DIST_W-1:0] tol_ext;
  logic [DIST_W-1:0]        s0_abs;
  logic [DIST_W-1:0]        s1_abs;
  logic [SMAG_W-1:0]        s0m_r;
  logic [DEN_W-1:0]         den_r;
  logic [CRD_W-1:0]         dm_r [AXES];
  side_t                    side3_r;

  assign hit_nxt = (s0 < 0 && s1 > 0) || (s0 > 0 && s1 < 0);
  assign tol_ext = $signed({{(DIST_W-TOL_W-FRAC_W){1'b0}}, tol_r, {FRAC_W{1'b0}}});
  assign sop_nxt = (s0 < tol_ext) && (s0 > -tol_ext);
  assign s0_abs  = s0[DIST_W-1] ? DIST_W'(-s0) : DIST_W'(s0);
  assign s1_abs  = s1[DIST_W-1] ? DIST_W'(-s1) : DIST_W'(s1);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s0m_r       <= s0_abs[SMAG_W-1:0];
      den_r       <= DEN_W'(s0_abs[SMAG_W-1:0]) + DEN_W'(s1_abs[SMAG_W-1:0]);
      side3_r.hit <= hit_nxt;
      side3_r.sop <= sop_nxt;
      for (int i = 0; i < AXES; i++) begin
        side3_r.org[i] <= a2_r[i];
        side3_r.neg[i] <= d2_r[i][DIF_W-1];
        dm_r[i]        <= d2_r[i][DIF_W-1] ? CRD_W'(-d2_r[i]) : CRD_W'(d2_r[i]);
      end
    end
  end

  // Stages 4 to 5+DIV_STEPS: divider lanes, side data held in step.
  localparam int LAST_DIV = DIV_STEPS + 5;

  side_t                side_r [4:LAST_DIV];
  logic [DIV_STEPS-1:0] quo  [AXES];
  logic [DEN_W-1:0]     rem  [AXES];
  logic [DEN_W-1:0]     dend [AXES];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      side_r[4] <= side3_r;
    end
    for (int k = 5; k <= LAST_DIV; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    spi_div u_div (
      .clk   (clk),
      .en    (en[LAST_DIV:4]),
      .dm    (dm_r[g]),
      .s0m   (s0m_r),
      .den   (den_r),
      .quo   (quo[g]),
      .rem   (rem[g]),
      .den_o (dend[g])
    );
  end

  // Last stage: round to nearest (ties away), step from the start point,
  // clamp to Q16.16, zero the point when there is no crossing.
  logic [Q_W-1:0]          qr  [AXES];
  logic signed [SUM_W-1:0] sum [AXES];
  logic [CRD_W-1:0]        pt  [AXES];
  logic [CRD_W-1:0]        cross_r [AXES];
  logic                    hit_r;
  logic                    sop_r;
  side_t                   sd;

  assign sd = side_r[LAST_DIV];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      qr[i]  = Q_W'(quo[i]) + Q_W'({rem[i], 1'b0} >= {1'b0, dend[i]});
      sum[i] = sd.neg[i]
             ? $signed({{2{sd.org[i][CRD_W-1]}}, sd.org[i]}) - $signed({1'b0, qr[i]})
             : $signed({{2{sd.org[i][CRD_W-1]}}, sd.org[i]}) + $signed({1'b0, qr[i]});
      if (!sd.hit) begin
        pt[i] = '0;
      end else if (sum[i] > $signed({2'b00, 1'b0, {(CRD_W-1){1'b1}}})) begin
        pt[i] = {1'b0, {(CRD_W-1){1'b1}}};
      end else if (sum[i] < $signed({2'b11, 1'b1, {(CRD_W-1){1'b0}}})) begin
        pt[i] = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
        pt[i] = sum[i][CRD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NUM_STAGES]) begin
      hit_r <= sd.hit;
      sop_r <= sd.sop;
      for (int i = 0; i < AXES; i++) begin
        cross_r[i] <= pt[i];
      end
    end
  end

  assign out_bus.valid          = v_r[NUM_STAGES];
  assign out_bus.hit            = hit_r;
  assign out_bus.cross_x        = cross_r[0];
  assign out_bus.cross_y        = cross_r[1];
  assign out_bus.cross_z        = cross_r[2];
  assign out_bus.start_on_plane = sop_r;

endmodule

### hdl/spi_check.sv
// ----------------------------------------------------------------------------
// spi_check
// Port-level checks for segment_plane_intersection, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spi_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_cross_x,
  input logic [31:0] out_cross_y,
  input logic [31:0] out_cross_z
);

  `SPI_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result beat right after reset")
  `SPI_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input stalled with empty output")
  `SPI_ASSERT_NOW(a_miss_zero, out_valid && !out_hit,
    out_cross_x == 32'd0 && out_cross_y == 32'd0 && out_cross_z == 32'd0,
    "nonzero point on a miss")
  `SPI_ASSERT_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(out_cross_x) && $stable(out_hit), "stalled result changed")

endmodule

bind segment_plane_intersection spi_check u_spi_check (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_hit     (out_bus.hit),
  .out_cross_x (out_bus.cross_x),
  .out_cross_y (out_bus.cross_y),
  .out_cross_z (out_bus.cross_z)
);
